>>> hw/rtl/mlqs_pkg.sv
// package: constants, types and state codes of the multilevel queue scheduler
`default_nettype none
package mlqs_pkg;

  localparam int unsigned NumCpusDefault      = 4;
  localparam int unsigned NumLevelsDefault    = 8;
  localparam int unsigned FifoDepthDefault    = 16;
  localparam int unsigned ThreadIdBitsDefault = 8;

  localparam logic [31:0] TimeSliceReset = 32'd10000000;
  localparam int unsigned TimeBits       = 48;

  // request kinds
  typedef enum logic {
    KIND_PUSH  = 1'b0,
    KIND_SCHED = 1'b1
  } kind_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_PLACE,
    ST_SCAN,
    ST_POP_RD,
    ST_POP_WAIT,
    ST_POP_DONE,
    ST_RESULT
  } state_e;

endpackage
`default_nettype wire

>>> hw/rtl/mlqs_if.sv
// valid/ready channel interfaces for requests, results and configuration
`default_nettype none
interface mlqs_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [1:0]  cpu;
  logic [7:0]  thread_id;
  logic [2:0]  priority_req;
  logic        boost;
  logic [2:0]  preferred_cpu;
  logic        running_leaves;
  logic [47:0] now;
  modport source (output valid, kind, cpu, thread_id, priority_req, boost, preferred_cpu,
                  running_leaves, now, input ready);
  modport sink   (input valid, kind, cpu, thread_id, priority_req, boost, preferred_cpu,
                  running_leaves, now, output ready);
endinterface

interface mlqs_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] running_thread;
  logic       running_valid;
  logic       switched;
  logic [1:0] target_cpu;
  logic       target_valid;
  logic       signal_needed;
  logic       queue_full;
  modport source (output valid, running_thread, running_valid, switched, target_cpu,
                  target_valid, signal_needed, queue_full, input ready);
  modport sink   (input valid, running_thread, running_valid, switched, target_cpu,
                  target_valid, signal_needed, queue_full, output ready);
endinterface

interface mlqs_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/mlqs_ram.sv
// generic single-port-write, single-read ram with registered read data
`default_nettype none
module mlqs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> hw/rtl/multilevel_queue_thread_scheduler.sv
// Multilevel queue thread scheduler: one ready FIFO per CPU and priority level.
//
// Channels: req_if (sink) takes push or schedule requests, rsp_if (source)
// returns one result per request, cfg_if (sink) writes time_slice while idle.
// A push places the thread on the least-loaded CPU (the preferred CPU counts
// one less); a schedule request pops the highest allowed non-empty level of
// one CPU and requeues a preempted thread. Thread entries live in one ram of
// NUM_CPUS*NUM_LEVELS*FIFO_DEPTH words; FIFO pointers and counts are
// flip-flops cleared at reset. One request at a time: a push takes NUM_CPUS
// load steps, then a place step and a result step; a schedule takes up to
// NUM_LEVELS scan steps (the last one issues the ram read), a wait step for
// the read data, on preemption the same load sweep and place, then a commit
// and a result step. The load sweep visits one CPU per cycle, the scan one
// level per cycle.
// The result waits in an output register until taken; the next request is
// accepted no earlier than the cycle after the result is taken. Reset
// empties every FIFO and marks every CPU idle; no clearing pass is needed.
`default_nettype none
module multilevel_queue_thread_scheduler
  import mlqs_pkg::*;
#(
  parameter int unsigned NUM_CPUS       = NumCpusDefault,
  parameter int unsigned NUM_LEVELS     = NumLevelsDefault,
  parameter int unsigned FIFO_DEPTH     = FifoDepthDefault,
  parameter int unsigned THREAD_ID_BITS = ThreadIdBitsDefault
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  mlqs_req_if.sink   req_if,
  mlqs_rsp_if.source rsp_if,
  mlqs_cfg_if.sink   cfg_if
);
  localparam int unsigned NQ    = NUM_CPUS * NUM_LEVELS;
  localparam int unsigned CB    = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int unsigned LB    = $clog2(NUM_LEVELS);
  localparam int unsigned PB    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned QB    = $clog2(NQ) > 0 ? $clog2(NQ) : 1;
  localparam int unsigned NB    = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned LDB   = $clog2(NQ * FIFO_DEPTH + 2) + 1;
  localparam int unsigned EW    = THREAD_ID_BITS + LB;
  localparam int unsigned DEPTH = NQ * FIFO_DEPTH;
  localparam int unsigned AB    = $clog2(DEPTH);

  state_e state_q, state_d;

  logic [31:0]             slice_q;
  logic [PB-1:0]           head_q [NQ];
  logic [PB-1:0]           tail_q [NQ];
  logic [NB-1:0]           cnt_q  [NQ];
  logic [THREAD_ID_BITS-1:0] rid_q  [NUM_CPUS];
  logic                    rpres_q [NUM_CPUS];
  logic [LB-1:0]           rbase_q [NUM_CPUS];
  logic [LB-1:0]           rlvl_q  [NUM_CPUS];
  logic [TimeBits-1:0]     send_q  [NUM_CPUS];

  // latched request
  logic                      kind_q;
  logic [1:0]                cpu_q;
  logic [THREAD_ID_BITS-1:0] pid_q;
  logic [LB-1:0]             pprio_q;
  logic [LB-1:0]             plvl_q;
  logic [2:0]                pref_q;
  logic [TimeBits-1:0]       now_q;

  // sweep registers
  logic [CB-1:0]  ci_q;
  logic [LB-1:0]  li_q;
  logic [LDB-1:0] best_len_q;
  logic [CB-1:0]  best_q;
  logic           best_set_q;
  logic [LB-1:0]  poplvl_q;

  // result register
  logic [7:0] o_thread_q;
  logic       o_rvalid_q, o_sw_q, o_tvalid_q, o_sig_q, o_full_q, o_valid_q;
  logic [1:0] o_tgt_q;

  // ram ports
  logic          we;
  logic [AB-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;

  mlqs_ram #(.Width(EW), .Depth(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  logic          sched_cpu_ok;
  logic [CB-1:0] scpu;
  assign sched_cpu_ok = (32'(req_if.cpu) < NUM_CPUS);
  assign scpu         = CB'(cpu_q);

  function automatic logic sched_cpu_ok_q();
    return (32'(cpu_q) < NUM_CPUS);
  endfunction

  // load of the cpu under the sweep, less one for the preferred cpu
  logic [LDB-1:0] cur_len;
  always_comb begin
    cur_len = {LDB{1'b0}};
    for (int l = 0; l < NUM_LEVELS; l++) begin
      cur_len = cur_len + LDB'(cnt_q[32'(ci_q) * NUM_LEVELS + l]);
    end
    cur_len = cur_len + LDB'(rpres_q[ci_q]);
    if (32'(pref_q) == 32'(ci_q)) begin
      cur_len = cur_len - LDB'(1);
    end
  end

  logic [QB-1:0] place_q_idx, scan_q_idx;
  assign place_q_idx = QB'(32'(best_q) * NUM_LEVELS + 32'(plvl_q));
  assign scan_q_idx  = QB'(32'(scpu) * NUM_LEVELS + 32'(li_q));

  logic place_full;
  assign place_full = (32'(cnt_q[place_q_idx]) >= FIFO_DEPTH);

  logic guard;
  assign guard = rpres_q[scpu] && (send_q[scpu] > now_q);

  assign req_if.ready = (state_q == ST_IDLE) && !o_valid_q;
  assign cfg_if.ready = (state_q == ST_IDLE) && !o_valid_q;
  assign rsp_if.valid          = o_valid_q;
  assign rsp_if.running_thread = o_thread_q;
  assign rsp_if.running_valid  = o_rvalid_q;
  assign rsp_if.switched       = o_sw_q;
  assign rsp_if.target_cpu     = o_tgt_q;
  assign rsp_if.target_valid   = o_tvalid_q;
  assign rsp_if.signal_needed  = o_sig_q;
  assign rsp_if.queue_full     = o_full_q;

  // next state and ram addressing
  always_comb begin
    state_d = state_q;
    we      = 1'b0;
    waddr   = AB'(32'(place_q_idx) * FIFO_DEPTH + 32'(tail_q[place_q_idx]));
    wdata   = {pprio_q, pid_q};
    raddr   = AB'(32'(scan_q_idx) * FIFO_DEPTH + 32'(head_q[scan_q_idx]));
    case (state_q)
      ST_IDLE: begin
        if (req_if.valid && req_if.ready) begin
          if (req_if.kind == KIND_PUSH) begin
            state_d = ST_LOAD;
          end else if (sched_cpu_ok) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_RESULT;
          end
        end
      end
      ST_LOAD:  if (32'(ci_q) == 0) state_d = ST_PLACE;
      ST_PLACE: begin
        we      = !place_full;
        state_d = (kind_q == KIND_PUSH) ? ST_RESULT : ST_POP_DONE;
      end
      ST_SCAN: begin
        if (cnt_q[scan_q_idx] != '0) begin
          state_d = ST_POP_WAIT;
        end else if (li_q == '0 || (guard && li_q <= rlvl_q[scpu])) begin
          state_d = ST_RESULT;
        end
      end
      ST_POP_WAIT: state_d = rpres_q[scpu] ? ST_LOAD : ST_POP_DONE;
      ST_POP_DONE: state_d = ST_RESULT;
      ST_RESULT:   state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath and queue bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_q   <= TimeSliceReset;
      o_valid_q <= 1'b0;
      for (int q = 0; q < NQ; q++) begin
        head_q[q] <= '0;
        tail_q[q] <= '0;
        cnt_q[q]  <= '0;
      end
      for (int c = 0; c < NUM_CPUS; c++) begin
        rid_q[c]   <= '0;
        rpres_q[c] <= 1'b0;
        rbase_q[c] <= '0;
        rlvl_q[c]  <= '0;
        send_q[c]  <= '0;
      end
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        slice_q <= cfg_if.data;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        o_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (req_if.valid && req_if.ready) begin
            kind_q  <= req_if.kind;
            cpu_q   <= req_if.cpu;
            pref_q  <= req_if.preferred_cpu;
            now_q   <= req_if.now;
            pid_q   <= THREAD_ID_BITS'(req_if.thread_id);
            begin
              logic [31:0] p, lv;
              p  = (32'(req_if.priority_req) > NUM_LEVELS - 1) ? NUM_LEVELS - 1
                                                                : 32'(req_if.priority_req);
              lv = (p + 32'(req_if.boost) <= NUM_LEVELS - 1) ? p + 32'(req_if.boost) : p;
              pprio_q <= LB'(p);
              plvl_q  <= LB'(lv);
            end
            ci_q       <= CB'(NUM_CPUS - 1);
            li_q       <= LB'(NUM_LEVELS - 1);
            best_set_q <= 1'b0;
            best_q     <= '0;
            o_thread_q <= '0; o_rvalid_q <= 1'b0; o_sw_q <= 1'b0;
            o_tgt_q <= '0; o_tvalid_q <= 1'b0; o_sig_q <= 1'b0; o_full_q <= 1'b0;
            if (req_if.kind == KIND_SCHED && sched_cpu_ok && req_if.running_leaves) begin
              rpres_q[CB'(req_if.cpu)] <= 1'b0;
            end
          end
        end
        ST_LOAD: begin
          // strict compare from the top index keeps the highest on a tie
          if (!best_set_q || $signed(cur_len) < $signed(best_len_q)) begin
            best_len_q <= cur_len;
            best_q     <= ci_q;
            best_set_q <= 1'b1;
          end
          ci_q <= ci_q - CB'(1);
        end
        ST_PLACE: begin
          o_tgt_q <= 2'(best_q);
          if (place_full) begin
            o_full_q <= 1'b1;
          end else begin
            o_tvalid_q <= 1'b1;
            o_sig_q    <= (32'(best_q) != 32'(cpu_q));
            tail_q[place_q_idx] <= (32'(tail_q[place_q_idx]) + 1 == FIFO_DEPTH) ? '0
                                   : tail_q[place_q_idx] + PB'(1);
            cnt_q[place_q_idx]  <= cnt_q[place_q_idx] + NB'(1);
          end
        end
        ST_SCAN: begin
          if (cnt_q[scan_q_idx] != '0) begin
            poplvl_q <= li_q;
            head_q[scan_q_idx] <= (32'(head_q[scan_q_idx]) + 1 == FIFO_DEPTH) ? '0
                                  : head_q[scan_q_idx] + PB'(1);
            cnt_q[scan_q_idx]  <= cnt_q[scan_q_idx] - NB'(1);
          end else begin
            li_q <= li_q - LB'(1);
          end
        end
        ST_POP_WAIT: begin
          // preempted thread goes back at its base level with boost zero
          pid_q   <= rid_q[scpu];
          pprio_q <= rbase_q[scpu];
          plvl_q  <= rbase_q[scpu];
          pref_q  <= 3'(cpu_q);
          rid_q[scpu]   <= rdata[THREAD_ID_BITS-1:0];
          rbase_q[scpu] <= rdata[EW-1:THREAD_ID_BITS];
          rlvl_q[scpu]  <= poplvl_q;
          send_q[scpu]  <= now_q + TimeBits'(slice_q);
        end
        ST_POP_DONE: begin
          rpres_q[scpu] <= 1'b1;
          o_sw_q        <= 1'b1;
        end
        ST_RESULT: begin
          o_valid_q <= 1'b1;
          if (kind_q == KIND_SCHED && sched_cpu_ok_q()) begin
            o_rvalid_q <= rpres_q[scpu];
            o_thread_q <= rpres_q[scpu] ? 8'(rid_q[scpu]) : 8'd0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/mlqs_checker.sv
// port-level checker for the scheduler, bound to the top level
`default_nettype none
module mlqs_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic req_valid, req_ready, req_kind,
  input wire logic rsp_valid, rsp_ready,
  input wire logic rsp_tvalid, rsp_full, rsp_sig, rsp_sw, rsp_rvalid
);
  a_one_outstanding: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> !req_ready) else $error("request taken while result pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> !(rsp_tvalid && rsp_full)) else $error("placed and full");
  a_sig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_sig |-> rsp_tvalid) else $error("signal without placement");
  a_sw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_sw |-> rsp_rvalid) else $error("switch without runner");
endmodule

bind multilevel_queue_thread_scheduler mlqs_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .req_valid(req_if.valid), .req_ready(req_if.ready), .req_kind(req_if.kind),
  .rsp_valid(rsp_if.valid), .rsp_ready(rsp_if.ready),
  .rsp_tvalid(rsp_if.target_valid), .rsp_full(rsp_if.queue_full),
  .rsp_sig(rsp_if.signal_needed), .rsp_sw(rsp_if.switched), .rsp_rvalid(rsp_if.running_valid)
);
`default_nettype wire
